>>> hdl/bf4h_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the four-hash Bloom filter: hash step codes, multiplier
// constants and the seven_mod seed function. No dependencies.
package bf4h_pkg;

    // Hash update steps, run in this order for every input byte
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_WGT  = 3'd1;
    localparam logic [2:0] OP_P19  = 3'd2;
    localparam logic [2:0] OP_POLY = 3'd3;
    localparam logic [2:0] OP_SHF  = 3'd4;
    localparam logic [2:0] OP_P7   = 3'd5;

    localparam logic [7:0] MUL_ONE  = 8'd1;
    localparam logic [7:0] MUL_19   = 8'd19;
    localparam logic [7:0] MUL_31   = 8'd31;
    localparam logic [7:0] MUL_7    = 8'd7;

    // Seed of the polynomial hash, 7 mod n, for n from 1 to 7
    function automatic logic [2:0] seven_mod(input logic [2:0] n);
        logic [2:0] r;
        case (n)
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd2;
            3'd6:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/bloom_filter_four_hash_unit.sv
`timescale 1ns / 1ps
// Four-hash Bloom filter, one byte per input transfer; tlast ends a word.
// Each byte runs six hash updates through one shared multiply-add and a
// bit-serial remainder unit; the dividend is DW = log2(MAX_BITS)+9 bits wide.
// A last byte then sets (insert) or reads and ANDs (query) the four indexed bits.
// After reset a clearing pass zeroes the bit store, input held off.
// Depends on bf4h_pkg, bf4h_reducer, bf4h_bitstore.
module bloom_filter_four_hash_unit #(
    parameter int MAX_BITS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        bit_count_we,
    input  logic [16:0] bit_count_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] mode (1 insert, 0 query)
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] may_contain, [7:1] zero
);

    localparam int HW = $clog2(MAX_BITS);
    localparam int NW = $clog2(MAX_BITS + 1);
    localparam int DW = HW + 9;
    localparam int RESET_BITS = (65536 > MAX_BITS) ? MAX_BITS : 65536;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_RED    = 3'd3;
    localparam logic [2:0] S_MEM    = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [NW-1:0] n_reg;
    logic [2:0]    op_reg;
    logic [1:0]    k_reg;
    logic [HW-1:0] clr_cnt_reg;
    logic          mode_reg;
    logic          last_reg;
    logic [7:0]    byte_reg;

    logic [HW-1:0] add_hash_reg;
    logic [HW-1:0] wgt_hash_reg;
    logic [HW-1:0] poly_hash_reg;
    logic [HW-1:0] shf_hash_reg;
    logic [HW-1:0] p19_reg;
    logic [HW-1:0] p7_reg;
    logic [HW-1:0] idx_reg [4];

    logic          hit_reg;
    logic          rd_valid_reg;
    logic          out_valid_reg;
    logic          out_bit_reg;

    logic [HW-1:0] mac_a;
    logic [7:0]    mac_m;
    logic [DW-1:0] mac_c;
    logic [HW+7:0] mac_prod;
    logic [DW-1:0] mac_sum;
    logic          red_start;
    logic          red_done;
    logic [HW-1:0] red_rem;

    logic [HW-1:0] one_mod;
    logic [HW-1:0] seven_mod_n;
    logic [31:0]   cfg_wide;

    logic          mem_we;
    logic          mem_wbit;
    logic          mem_re;
    logic [HW-1:0] mem_addr;
    logic          mem_rdata;

    // ---------------- configuration ----------------
    assign cfg_wide = 32'(bit_count_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NW'(RESET_BITS);
        end
        else if (bit_count_we)
        begin
            if (cfg_wide == 32'd0)
            begin
                n_reg <= NW'(1);
            end
            else if (cfg_wide > 32'(MAX_BITS))
            begin
                n_reg <= NW'(MAX_BITS);
            end
            else
            begin
                n_reg <= NW'(cfg_wide);
            end
        end
    end

    // word seeds under the current size
    assign one_mod     = (n_reg == NW'(1)) ? '0 : HW'(1);
    assign seven_mod_n = (n_reg > NW'(7)) ? HW'(7) : HW'(bf4h_pkg::seven_mod(n_reg[2:0]));

    // ---------------- shared multiply-add ----------------
    always_comb
    begin
        unique case (op_reg)
            bf4h_pkg::OP_ADD:
            begin
                mac_a = add_hash_reg;
                mac_m = bf4h_pkg::MUL_ONE;
                mac_c = DW'(byte_reg);
            end
            bf4h_pkg::OP_WGT:
            begin
                mac_a = p19_reg;
                mac_m = byte_reg;
                mac_c = DW'(wgt_hash_reg);
            end
            bf4h_pkg::OP_P19:
            begin
                mac_a = p19_reg;
                mac_m = bf4h_pkg::MUL_19;
                mac_c = '0;
            end
            bf4h_pkg::OP_POLY:
            begin
                mac_a = poly_hash_reg;
                mac_m = bf4h_pkg::MUL_31;
                mac_c = DW'(byte_reg);
            end
            bf4h_pkg::OP_SHF:
            begin
                mac_a = p7_reg;
                mac_m = byte_reg;
                mac_c = DW'({shf_hash_reg, 3'b000});
            end
            bf4h_pkg::OP_P7:
            begin
                mac_a = p7_reg;
                mac_m = bf4h_pkg::MUL_7;
                mac_c = '0;
            end
            default:
            begin
                mac_a = '0;
                mac_m = '0;
                mac_c = '0;
            end
        endcase
        mac_prod = (HW + 8)'(mac_a) * (HW + 8)'(mac_m);
        mac_sum  = DW'(mac_prod) + mac_c;
    end

    assign red_start = (state_reg == S_LOAD);

    bf4h_reducer #(
        .DW (DW),
        .NW (NW),
        .HW (HW)
    ) u_reducer (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .dividend  (mac_sum),
        .modulus   (n_reg),
        .done      (red_done),
        .remainder (red_rem)
    );

    // ---------------- bit store ----------------
    assign mem_we   = (state_reg == S_CLEAR) || ((state_reg == S_MEM) && mode_reg);
    assign mem_wbit = (state_reg == S_MEM);
    assign mem_re   = (state_reg == S_MEM) && !mode_reg;
    assign mem_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : idx_reg[k_reg];

    bf4h_bitstore #(
        .DEPTH (MAX_BITS),
        .AW    (HW)
    ) u_bitstore (
        .clk   (clk),
        .we    (mem_we),
        .wbit  (mem_wbit),
        .re    (mem_re),
        .addr  (mem_addr),
        .rdata (mem_rdata)
    );

    // ---------------- sequencer ----------------
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == HW'(MAX_BITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                if (red_done)
                begin
                    if (op_reg != bf4h_pkg::OP_P7)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_MEM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MEM:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = mode_reg ? S_IDLE : S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            op_reg        <= bf4h_pkg::OP_ADD;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            add_hash_reg  <= '0;
            wgt_hash_reg  <= HW'(1);
            poly_hash_reg <= HW'(7);
            shf_hash_reg  <= HW'(3);
            p19_reg       <= HW'(1);
            p7_reg        <= HW'(1);
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_re;

            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                op_reg <= bf4h_pkg::OP_ADD;
            end

            if ((state_reg == S_RED) && red_done)
            begin
                op_reg <= op_reg + 1'b1;
                // last byte: reseed every running hash for the next word
                if ((op_reg == bf4h_pkg::OP_P7) && last_reg)
                begin
                    add_hash_reg  <= '0;
                    wgt_hash_reg  <= one_mod;
                    poly_hash_reg <= seven_mod_n;
                    shf_hash_reg  <= HW'(3);
                    p19_reg       <= one_mod;
                    p7_reg        <= one_mod;
                    k_reg         <= '0;
                    hit_reg       <= 1'b1;
                end
                else
                begin
                    case (op_reg)
                        bf4h_pkg::OP_ADD:  add_hash_reg  <= red_rem;
                        bf4h_pkg::OP_WGT:  wgt_hash_reg  <= red_rem;
                        bf4h_pkg::OP_P19:  p19_reg       <= red_rem;
                        bf4h_pkg::OP_POLY: poly_hash_reg <= red_rem;
                        bf4h_pkg::OP_SHF:  shf_hash_reg  <= red_rem;
                        default:           p7_reg        <= red_rem;
                    endcase
                end
            end

            if (state_reg == S_MEM)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (rd_valid_reg)
            begin
                hit_reg <= hit_reg & mem_rdata;
            end

            if ((state_reg == S_OUT) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
            mode_reg <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        // capture the finished indices before the hashes are reseeded
        if ((state_reg == S_RED) && red_done && (op_reg == bf4h_pkg::OP_P7) && last_reg)
        begin
            idx_reg[0] <= add_hash_reg;
            idx_reg[1] <= wgt_hash_reg;
            idx_reg[2] <= poly_hash_reg;
            idx_reg[3] <= shf_hash_reg;
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || m_axis_tready))
        begin
            out_bit_reg <= hit_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_bit_reg};

    // ---------------- checks ----------------
    a_size_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != '0) && (32'(n_reg) <= 32'(MAX_BITS)))
        else $error("bit count out of range");

    a_done_in_red: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> (state_reg == S_RED))
        else $error("reducer finished outside a reduction step");

    a_mem_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) || ((state_reg == S_MEM) && mode_reg)))
        else $error("bit store written outside clear or insert");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready)
            |=> ((state_reg == S_LOAD) && (op_reg == bf4h_pkg::OP_ADD)))
        else $error("accepted byte did not start the hash sequence");

    a_op_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (op_reg <= bf4h_pkg::OP_P7))
        else $error("hash step code past the last step");

endmodule

>>> hdl/bf4h_reducer.sv
`timescale 1ns / 1ps
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Standalone; used by bloom_filter_four_hash_unit.
module bf4h_reducer #(
    parameter int DW = 25,
    parameter int NW = 17,
    parameter int HW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] modulus,
    output logic          done,
    output logic [HW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] div_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] rem_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW:0]   trial;

    always_comb
    begin
        trial = {rem_reg, div_reg[DW-1]};
        if (trial >= {1'b0, modulus})
        begin
            rem_next = NW'(trial - {1'b0, modulus});
        end
        else
        begin
            rem_next = NW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[DW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    // rem_reg stays below the modulus, which never exceeds the bit store depth
    assign remainder = HW'(rem_reg);

endmodule

>>> hdl/bf4h_bitstore.sv
`timescale 1ns / 1ps
// Presence bit store: single-port memory, one bit per entry, registered read.
// Standalone; used by bloom_filter_four_hash_unit.
module bf4h_bitstore #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic          wbit,
    input  logic          re,
    input  logic [AW-1:0] addr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wbit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
